// ===== design/ctc_pkg.sv =====
package ctc_pkg;

    localparam int unsigned TICKS_PER_SECOND = 128;
    localparam int unsigned PRESCALE_W =
        (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(TICKS_PER_SECOND - 1);

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [2:0] REG_SEC  = 3'd0;
    localparam logic [2:0] REG_MIN  = 3'd1;
    localparam logic [2:0] REG_HOUR = 3'd2;
    localparam logic [2:0] REG_DAY  = 3'd3;
    localparam logic [2:0] REG_CTRL = 3'd4;

    localparam int unsigned CTRL_DAY8_BIT  = 0;
    localparam int unsigned CTRL_HALT_BIT  = 6;
    localparam int unsigned CTRL_CARRY_BIT = 7;

    localparam logic [8:0] SEC_MOD  = 9'd60;
    localparam logic [8:0] MIN_MOD  = 9'd60;
    localparam logic [8:0] HOUR_MOD = 9'd24;

    localparam logic [7:0] READ_OOR = 8'hFF;

    // (v + 1) mod n for 8-bit v and n in 24..60; restoring subtract, 4 steps
    function automatic logic [7:0] inc_mod(input logic [7:0] v, input logic [8:0] n);
        logic [8:0] s;
        logic [8:0] m;
        s = {1'b0, v} + 9'd1;
        for (int k = 3; k >= 0; k--) begin
            m = n << k;
            if (s >= m) begin
                s = s - m;
            end
        end
        return s[7:0];
    endfunction

endpackage

// ===== design/cartridge_rtc_counter_core.sv =====
// Cartridge real-time clock: seconds, minutes, hours, day-low and control
// (bit 0 day bit 8, bit 6 halt, bit 7 sticky day carry). A tick beat advances a
// prescaler unless halted; every TICKS_PER_SECOND ticks the seconds step and
// cascade through minutes, hours and days. Read beats return one byte (0xFF for
// an index above 4); tick and write beats return nothing. Each beat is held in
// the input register and applied from there; a read result then sits in the
// output register. One beat per cycle is sustained while the output side takes
// results.
module cartridge_rtc_counter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [2:0] i_reg_index,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data
);
    import ctc_pkg::*;

    logic                  r_in_valid;
    logic [1:0]            r_func;
    logic [2:0]            r_idx;
    logic [7:0]            r_wdata;

    logic [PRESCALE_W-1:0] r_prescale, n_prescale;
    logic [7:0]            r_sec, n_sec;
    logic [7:0]            r_min, n_min;
    logic [7:0]            r_hour, n_hour;
    logic [7:0]            r_day, n_day;
    logic [7:0]            r_ctrl, n_ctrl;

    logic                  r_out_valid;
    logic [7:0]            r_out_data, n_out_data;

    logic                  w_is_read;
    logic                  w_advance;
    logic                  w_fire;
    logic [7:0]            w_sec_inc, w_min_inc, w_hour_inc, w_day_inc, w_ctrl_tog;

    assign w_is_read = (r_func == FUNC_READ);
    assign w_advance = r_in_valid && (!w_is_read || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign o_valid   = r_out_valid;
    assign o_read_data = r_out_data;

    assign w_sec_inc  = inc_mod(r_sec, SEC_MOD);
    assign w_min_inc  = inc_mod(r_min, MIN_MOD);
    assign w_hour_inc = inc_mod(r_hour, HOUR_MOD);
    assign w_day_inc  = r_day + 8'd1;
    assign w_ctrl_tog = r_ctrl ^ (8'd1 << CTRL_DAY8_BIT);

    assign w_fire = (r_func == FUNC_TICK) && !r_ctrl[CTRL_HALT_BIT]
                    && (r_prescale == PRESCALE_LAST);

    always_comb begin
        n_prescale = r_prescale;
        n_sec      = r_sec;
        n_min      = r_min;
        n_hour     = r_hour;
        n_day      = r_day;
        n_ctrl     = r_ctrl;
        n_out_data = r_out_data;
        case (r_func)
            FUNC_TICK: begin
                if (!r_ctrl[CTRL_HALT_BIT]) begin
                    n_prescale = w_fire ? '0 : r_prescale + PRESCALE_W'(1);
                end
                if (w_fire) begin
                    n_sec = w_sec_inc;
                    if (w_sec_inc == 8'd0) begin
                        n_min = w_min_inc;
                        if (w_min_inc == 8'd0) begin
                            n_hour = w_hour_inc;
                            if (w_hour_inc == 8'd0) begin
                                n_day = w_day_inc;
                                if (w_day_inc == 8'd0) begin
                                    n_ctrl = w_ctrl_tog;
                                    if (!w_ctrl_tog[CTRL_DAY8_BIT]) begin
                                        n_ctrl[CTRL_CARRY_BIT] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            FUNC_READ: begin
                case (r_idx)
                    REG_SEC:  n_out_data = r_sec;
                    REG_MIN:  n_out_data = r_min;
                    REG_HOUR: n_out_data = r_hour;
                    REG_DAY:  n_out_data = r_day;
                    REG_CTRL: n_out_data = r_ctrl;
                    default:  n_out_data = READ_OOR;
                endcase
            end
            FUNC_WRITE: begin
                case (r_idx)
                    REG_SEC:  n_sec  = r_wdata;
                    REG_MIN:  n_min  = r_wdata;
                    REG_HOUR: n_hour = r_wdata;
                    REG_DAY:  n_day  = r_wdata;
                    REG_CTRL: n_ctrl = r_wdata;
                    default:  ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prescale  <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_day       <= '0;
            r_ctrl      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_prescale <= n_prescale;
                r_sec      <= n_sec;
                r_min      <= n_min;
                r_hour     <= n_hour;
                r_day      <= n_day;
                r_ctrl     <= n_ctrl;
            end
            if (w_advance && w_is_read) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func  <= i_func;
            r_idx   <= i_reg_index;
            r_wdata <= i_write_data;
        end
        if (w_advance && w_is_read) begin
            r_out_data <= n_out_data;
        end
    end

    a_prescale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prescale <= PRESCALE_LAST)
        else $error("prescaler out of range");

    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_func == FUNC_TICK && r_ctrl[CTRL_HALT_BIT])
        |=> ($stable(r_prescale) && $stable(r_sec) && $stable(r_ctrl)))
        else $error("halted tick changed state");

    a_carry_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl[CTRL_CARRY_BIT] && !(w_advance && r_func == FUNC_WRITE && r_idx == REG_CTRL))
        |=> r_ctrl[CTRL_CARRY_BIT])
        else $error("carry cleared without a write");

    a_oor_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_read && r_idx > REG_CTRL) |=> (r_out_valid && r_out_data == READ_OOR))
        else $error("out-of-range read returned wrong data");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && !w_advance) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctc_pkg::*;

    localparam int unsigned NUM_CLOCK_REGS = 5;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [2:0] REG_OOR_FIRST = 3'd5;
    localparam logic [2:0] REG_OOR_LAST = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_func = FUNC_TICK;
    logic [2:0] i_reg_index = REG_SEC;
    logic [7:0] i_write_data = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_read_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_left = 0;
    int unsigned beats_sent = 0;
    int unsigned fail_count = 0;

    int unsigned rtc_prescale = 0;
    logic [7:0] rtc_regs [NUM_CLOCK_REGS];
    logic [7:0] pending_reads [$];

    cartridge_rtc_counter_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] wrap_inc(input logic [7:0] v, input int unsigned n);
        return 8'((int'(v) + 1) % n);
    endfunction

    function automatic void rtc_second_step();
        rtc_regs[REG_SEC] = wrap_inc(rtc_regs[REG_SEC], SEC_MOD);
        if (rtc_regs[REG_SEC] != 8'h00) return;
        rtc_regs[REG_MIN] = wrap_inc(rtc_regs[REG_MIN], MIN_MOD);
        if (rtc_regs[REG_MIN] != 8'h00) return;
        rtc_regs[REG_HOUR] = wrap_inc(rtc_regs[REG_HOUR], HOUR_MOD);
        if (rtc_regs[REG_HOUR] != 8'h00) return;
        rtc_regs[REG_DAY] = wrap_inc(rtc_regs[REG_DAY], 256);
        if (rtc_regs[REG_DAY] != 8'h00) return;
        rtc_regs[REG_CTRL][CTRL_DAY8_BIT] = ~rtc_regs[REG_CTRL][CTRL_DAY8_BIT];
        if (!rtc_regs[REG_CTRL][CTRL_DAY8_BIT]) rtc_regs[REG_CTRL][CTRL_CARRY_BIT] = 1'b1;
    endfunction

    function automatic void rtc_predict(input logic [1:0] func, input logic [2:0] idx,
                                        input logic [7:0] data);
        case (func)
            FUNC_TICK: begin
                if (!rtc_regs[REG_CTRL][CTRL_HALT_BIT]) begin
                    rtc_prescale++;
                    if (rtc_prescale >= TICKS_PER_SECOND) begin
                        rtc_prescale = 0;
                        rtc_second_step();
                    end
                end
            end
            FUNC_READ: begin
                if (idx <= REG_CTRL) pending_reads.push_back(rtc_regs[idx]);
                else pending_reads.push_back(READ_OOR);
            end
            FUNC_WRITE: begin
                if (idx <= REG_CTRL) rtc_regs[idx] = data;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] func, input logic [2:0] idx,
                             input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_reg_index <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_ready);
        rtc_predict(func, idx, data);
        beats_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // result checker and receiver-side ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reads.size() == 0) begin
                $error("read_data expected none actual %02h", o_read_data);
                fail_count++;
            end else begin
                if (o_read_data !== pending_reads[0]) begin
                    $error("read_data expected %02h actual %02h", pending_reads[0], o_read_data);
                    fail_count++;
                end
                void'(pending_reads.pop_front());
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic test_reset_values();
        for (int k = 0; k < 8; k++) send_beat(FUNC_READ, 3'(k), 8'($urandom));
    endtask

    task automatic test_write_readback();
        send_beat(FUNC_WRITE, REG_SEC, 8'hFF);
        send_beat(FUNC_WRITE, REG_HOUR, 8'h80);
        send_beat(FUNC_WRITE, REG_CTRL, 8'hC1);
        send_beat(FUNC_READ, REG_SEC, 8'h00);
        send_beat(FUNC_READ, REG_HOUR, 8'h00);
        send_beat(FUNC_READ, REG_CTRL, 8'h00);
    endtask

    task automatic test_halted_tick();
        send_beat(FUNC_TICK, REG_SEC, 8'h00);
        send_beat(FUNC_TICK, REG_OOR_LAST, 8'hFF);
        send_beat(FUNC_READ, REG_CTRL, 8'h00);
        send_beat(FUNC_WRITE, REG_CTRL, 8'h00);
    endtask

    task automatic test_out_of_range();
        send_beat(FUNC_WRITE, REG_OOR_LAST, 8'h5A);
        send_beat(FUNC_READ, REG_OOR_LAST, 8'h00);
        send_beat(FUNC_READ, REG_OOR_FIRST, 8'h00);
    endtask

    task automatic test_unknown_func();
        send_beat(FUNC_NONE, REG_SEC, 8'hA5);
        send_beat(FUNC_READ, REG_SEC, 8'h00);
    endtask

    task automatic run_noise(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 8'($urandom));
    endtask

    // arm the counters, mostly near their wrap points, tick, usually past a seconds rollover, read back
    task automatic run_rollover_sequence();
        logic [7:0] ctrl;
        int unsigned burst;
        ctrl = 8'($urandom);
        ctrl[CTRL_HALT_BIT] = ($urandom_range(0, 9) == 0);
        send_beat(FUNC_WRITE, REG_SEC,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(SEC_MOD - 1));
        send_beat(FUNC_WRITE, REG_MIN,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(MIN_MOD - 1));
        send_beat(FUNC_WRITE, REG_HOUR,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(HOUR_MOD - 1));
        send_beat(FUNC_WRITE, REG_DAY,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
        send_beat(FUNC_WRITE, REG_CTRL, ctrl);
        if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, 20);
        else burst = TICKS_PER_SECOND + $urandom_range(0, 16);
        for (int unsigned k = 0; k < burst; k++) begin
            if ($urandom_range(0, 99) < 4)
                send_beat(FUNC_READ, 3'($urandom_range(0, 7)), 8'($urandom));
            else
                send_beat(FUNC_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
        end
        for (int k = 0; k < NUM_CLOCK_REGS; k++) send_beat(FUNC_READ, 3'(k), 8'($urandom));
    endtask

    task automatic test_random_traffic(input int unsigned n);
        int unsigned target;
        target = beats_sent + n;
        while (beats_sent < target) begin
            if ($urandom_range(0, 99) < 60) run_rollover_sequence();
            else run_noise(16);
        end
    endtask

    task automatic test_output_stall();
        stall_left = 400;
        for (int k = 0; k < 40; k++)
            send_beat(FUNC_READ, 3'($urandom_range(0, 7)), 8'($urandom));
        drain_results();
    endtask

    initial begin
        for (int k = 0; k < NUM_CLOCK_REGS; k++) rtc_regs[k] = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_write_readback();
        test_halted_tick();
        test_out_of_range();
        test_unknown_func();
        drain_results();

        send_idle_pct = 16;
        recv_idle_pct = 49;
        test_random_traffic(500);
        drain_results();

        test_output_stall();

        send_idle_pct = 49;
        recv_idle_pct = 16;
        test_random_traffic(500);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(500);
        drain_results();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
